### sv/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// Used by bmhq_core and binary_min_heap_queue; depends on nothing else.
package bmhq_pkg;

  localparam int KEY_W      = 32;
  localparam int TAG_PORT_W = 16;
  localparam int CNT_PORT_W = 11;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_ROOT,
    S_LAST,
    S_LEFT,
    S_RIGHT,
    S_PLACE,
    S_POST
  } heap_state_t;

  typedef struct packed {
    logic                  kind;
    logic [KEY_W-1:0]      key;
    logic [TAG_PORT_W-1:0] tag;
  } heap_req_t;

  typedef struct packed {
    status_t               status;
    logic [KEY_W-1:0]      key;
    logic [TAG_PORT_W-1:0] tag;
    logic [CNT_PORT_W-1:0] count;
  } heap_rsp_t;

endpackage

### sv/bmhq_core.sv
// Heap storage and sift sequencer: one synchronous memory plus the FSM that
// walks it one level at a time. Depends on bmhq_pkg.
module bmhq_core #(
  parameter int HEAP_DEPTH   = 1024,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bmhq_pkg::heap_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_hold,
  output bmhq_pkg::heap_rsp_t rsp
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int TW = (PAYLOAD_BITS < TAG_PORT_W) ? PAYLOAD_BITS : TAG_PORT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(HEAP_DEPTH);
  localparam logic [CW-1:0] ROOT_POS   = CW'(1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TW-1:0]    tag;
  } entry_t;

  // Positions are one-based; the memory is indexed from zero.
  function automatic logic [AW-1:0] pos_idx(input logic [CW-1:0] p);
    logic [CW-1:0] t;
    t = p - ROOT_POS;
    return t[AW-1:0];
  endfunction

  entry_t mem [HEAP_DEPTH];
  entry_t rd_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  heap_state_t   state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] pos, pos_next;
  entry_t        mov, mov_next;
  entry_t        lft, lft_next;
  status_t       res_status, res_status_next;
  logic [KEY_W-1:0] res_key, res_key_next;
  logic [TW-1:0] res_tag, res_tag_next;

  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] up_pos;
  logic [CW:0]   cnt_ext;
  logic [CW:0]   left_pos;
  logic [CW:0]   right_pos;
  logic          decide;
  entry_t        pick;
  logic [CW:0]   pick_pos;
  logic [CW:0]   pick_left;
  logic [CW:0]   pick_left_idx;

  assign cnt_inc   = cnt + ROOT_POS;
  assign up_pos    = pos >> 1;
  assign cnt_ext   = {1'b0, cnt};
  assign left_pos  = {pos, 1'b0};
  assign right_pos = {pos, 1'b1};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    pos        <= pos_next;
    mov        <= mov_next;
    lft        <= lft_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    mov_next        = mov;
    lft_next        = lft;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = pos_idx(pos);
    wr_data         = mov;
    rsp_valid       = 1'b0;
    decide          = 1'b0;
    pick            = rd_q;
    pick_pos        = left_pos;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_key_next = '0;
          res_tag_next = '0;
          if (req.kind == KIND_INSERT) begin
            if (cnt == FULL_COUNT) begin
              res_status_next = ST_FULL;
              state_next      = S_POST;
            end else begin
              res_status_next = ST_INSERTED;
              mov_next.key    = req.key;
              mov_next.tag    = req.tag[TW-1:0];
              cnt_next        = cnt_inc;
              pos_next        = cnt_inc;
              if (cnt == '0) begin
                state_next = S_PLACE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pos_idx(cnt_inc >> 1);
                state_next = S_UP;
              end
            end
          end else begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_POST;
            end else begin
              res_status_next = ST_EXTRACTED;
              rd_en           = 1'b1;
              rd_addr         = '0;
              state_next      = S_ROOT;
            end
          end
        end
      end

      // The new word stays in a register; parents move down into the hole.
      S_UP: begin
        wr_en = 1'b1;
        if (mov.key < rd_q.key) begin
          wr_data  = rd_q;
          pos_next = up_pos;
          if (up_pos == ROOT_POS) begin
            state_next = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_idx(up_pos >> 1);
          end
        end else begin
          state_next = S_POST;
        end
      end

      S_ROOT: begin
        res_key_next = rd_q.key;
        res_tag_next = rd_q.tag;
        cnt_next     = cnt - ROOT_POS;
        rd_en        = 1'b1;
        rd_addr      = pos_idx(cnt);
        state_next   = S_LAST;
      end

      // The count has already dropped, so the last entry's slot is free.
      S_LAST: begin
        mov_next = rd_q;
        pos_next = ROOT_POS;
        if (cnt == '0) begin
          state_next = S_POST;
        end else if (cnt == ROOT_POS) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = rd_q;
          state_next = S_POST;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pos_idx(ROOT_POS + ROOT_POS);
          state_next = S_LEFT;
        end
      end

      S_LEFT: begin
        lft_next = rd_q;
        if (right_pos > cnt_ext) begin
          decide = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = left_pos[AW-1:0];
          state_next = S_RIGHT;
        end
      end

      // Equal children keys send the word to the right child.
      S_RIGHT: begin
        decide = 1'b1;
        if (lft.key < rd_q.key) begin
          pick     = lft;
          pick_pos = left_pos;
        end else begin
          pick     = rd_q;
          pick_pos = right_pos;
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        state_next = S_POST;
      end

      S_POST: begin
        if (!rsp_hold) begin
          rsp_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase

    pick_left     = {pick_pos[CW-1:0], 1'b0};
    pick_left_idx = pick_left - {{CW{1'b0}}, 1'b1};

    if (decide) begin
      wr_en = 1'b1;
      if (mov.key > pick.key) begin
        wr_data  = pick;
        pos_next = pick_pos[CW-1:0];
        if (pick_left > cnt_ext) begin
          state_next = S_PLACE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pick_left_idx[AW-1:0];
          state_next = S_LEFT;
        end
      end else begin
        state_next = S_POST;
      end
    end
  end

  logic [TAG_PORT_W+TW-1:0] tag_wide;
  logic [CNT_PORT_W+CW-1:0] cnt_wide;

  assign tag_wide   = {{TAG_PORT_W{1'b0}}, res_tag};
  assign cnt_wide   = {{CNT_PORT_W{1'b0}}, cnt};
  assign req_ready  = (state == S_IDLE);
  assign rsp.status = res_status;
  assign rsp.key    = res_key;
  assign rsp.tag    = tag_wide[TAG_PORT_W-1:0];
  assign rsp.count  = cnt_wide[CNT_PORT_W-1:0];

endmodule

### sv/binary_min_heap_queue.sv
// Binary min-heap priority queue. Each command word either inserts a key with
// its payload tag or extracts the entry with the smallest key; every command
// returns one result word with a status, the extracted key and tag (zero when
// nothing was extracted) and the entry count afterwards. The heap lives in one
// single-port-read, single-port-write memory of HEAP_DEPTH entries, and one
// command is processed at a time. An insert reads one parent per level that
// the new entry climbs, and an extract makes up to two child reads per level
// that the moved entry sinks. Full-on-insert and empty-on-extract return
// without touching the memory. A new command is taken while the previous
// result still waits in the output register.
// Depends on bmhq_pkg and bmhq_core.
module binary_min_heap_queue #(
  parameter int HEAP_DEPTH   = 1024,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic                                kind,
  input  logic [bmhq_pkg::KEY_W-1:0]          key_value,
  input  logic [bmhq_pkg::TAG_PORT_W-1:0]     payload_tag,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          status,
  output logic [bmhq_pkg::KEY_W-1:0]          min_key,
  output logic [bmhq_pkg::TAG_PORT_W-1:0]     min_payload,
  output logic [bmhq_pkg::CNT_PORT_W-1:0]     entry_count
);
  import bmhq_pkg::*;

  heap_req_t core_req;
  heap_rsp_t core_rsp;
  logic      core_ready;
  logic      core_done;
  logic      out_hold;

  assign core_req.kind = kind;
  assign core_req.key  = key_value;
  assign core_req.tag  = payload_tag;
  assign cmd_stall     = !core_ready;
  assign out_hold      = rsp_valid && rsp_stall;

  bmhq_core #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (cmd_valid),
    .req_ready (core_ready),
    .req       (core_req),
    .rsp_valid (core_done),
    .rsp_hold  (out_hold),
    .rsp       (core_rsp)
  );

  // The core only finishes when the output register is free to take the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= core_done || out_hold;
    end
    if (core_done) begin
      status      <= core_rsp.status;
      min_key     <= core_rsp.key;
      min_payload <= core_rsp.tag;
      entry_count <= core_rsp.count;
    end
  end

endmodule
